FILE: src/rtp_pkg.sv
package rtp_pkg;

	localparam int RANK_W  = 29;
	localparam int DIGIT_W = 4;
	localparam int FACT_TOP = 12;

	localparam logic [DIGIT_W-1:0] ELEMENT_COUNT_RESET = 4'd12;

	localparam logic [RANK_W-1:0] FACT [FACT_TOP+1] = '{
		29'd1, 29'd1, 29'd2, 29'd6, 29'd24, 29'd120, 29'd720, 29'd5040,
		29'd40320, 29'd362880, 29'd3628800, 29'd39916800, 29'd479001600
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_DIV,
		ST_PLACE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mod_step;
		logic       dig_step;
		logic [1:0] shift;
	} div_cmd_t;

	typedef struct packed {
		logic init;
		logic place;
	} slot_cmd_t;

endpackage

FILE: src/rtp_div_unit.sv
module rtp_div_unit (
	input  logic                             clk,
	input  rtp_pkg::div_cmd_t                cmd,
	input  logic [rtp_pkg::RANK_W-1:0]       rank,
	input  logic [rtp_pkg::RANK_W-1:0]       modulus,
	input  logic [rtp_pkg::RANK_W-1:0]       weight,
	output logic [rtp_pkg::DIGIT_W-1:0]      digit
);

	logic [rtp_pkg::RANK_W-1:0]  shift_q;
	logic [rtp_pkg::RANK_W-1:0]  rem_q;
	logic [rtp_pkg::DIGIT_W-1:0] quo_q;

	logic [rtp_pkg::RANK_W:0]    op_a;
	logic [rtp_pkg::RANK_W:0]    op_b;
	logic [rtp_pkg::RANK_W+1:0]  diff;
	logic                        ge;

	always_comb begin
		if (cmd.mod_step) begin
			op_a = {rem_q, shift_q[rtp_pkg::RANK_W-1]};
			op_b = {1'b0, modulus};
		end else begin
			op_a = {1'b0, rem_q};
			op_b = {1'b0, weight} << cmd.shift;
		end
		diff = {1'b0, op_a} - {1'b0, op_b};
		ge   = !diff[rtp_pkg::RANK_W+1];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			shift_q <= rank;
			rem_q   <= '0;
		end else if (cmd.mod_step) begin
			shift_q <= shift_q << 1;
			rem_q   <= ge ? diff[rtp_pkg::RANK_W-1:0] : op_a[rtp_pkg::RANK_W-1:0];
		end else if (cmd.dig_step) begin
			rem_q <= ge ? diff[rtp_pkg::RANK_W-1:0] : op_a[rtp_pkg::RANK_W-1:0];
			quo_q <= {quo_q[rtp_pkg::DIGIT_W-2:0], ge};
		end
	end

	assign digit = quo_q;

endmodule

FILE: src/rtp_slot_alloc.sv
module rtp_slot_alloc #(
	parameter int MAX_ELEMENTS = 12
) (
	input  logic                          clk,
	input  rtp_pkg::slot_cmd_t            cmd,
	input  logic [rtp_pkg::DIGIT_W-1:0]   digit,
	input  logic [rtp_pkg::DIGIT_W-1:0]   value,
	input  logic [rtp_pkg::DIGIT_W-1:0]   position,
	output logic [rtp_pkg::DIGIT_W-1:0]   element
);

	localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

	logic [rtp_pkg::DIGIT_W-1:0] free_q [MAX_ELEMENTS];
	logic [rtp_pkg::DIGIT_W-1:0] slot_q [MAX_ELEMENTS];
	logic [rtp_pkg::DIGIT_W-1:0] free_ext [MAX_ELEMENTS+1];
	logic [rtp_pkg::DIGIT_W-1:0] chosen;

	always_comb begin
		for (int k = 0; k < MAX_ELEMENTS; k++) begin
			free_ext[k] = free_q[k];
		end
		free_ext[MAX_ELEMENTS] = '0;
		chosen = free_q[digit[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			for (int k = 0; k < MAX_ELEMENTS; k++) begin
				free_q[k] <= rtp_pkg::DIGIT_W'(k);
			end
		end else if (cmd.place) begin
			slot_q[chosen[IDX_W-1:0]] <= value;
			for (int k = 0; k < MAX_ELEMENTS; k++) begin
				if (rtp_pkg::DIGIT_W'(k) >= digit) begin
					free_q[k] <= free_ext[k+1];
				end
			end
		end
	end

	assign element = slot_q[position[IDX_W-1:0]];

endmodule

FILE: src/rank_to_permutation.sv
// Turns a rank into a permutation of 1..n in factorial-base order, n taken from
// the element count register (0 reads as 1, values above MAX_ELEMENTS saturate).
// The rank is reduced modulo n! first. Each accepted item gives n result items,
// slot positions 0..n-1 in order, with last set on the final one. One shared
// trial-subtract unit does all arithmetic: a bit-serial restoring remainder of
// the rank for the modulo, then a restoring division for each factorial digit,
// each followed by placing the value into its free slot, then the results, held
// while result_stall is high. rank_stall stays high until the last is taken.
module rank_to_permutation #(
	parameter int MAX_ELEMENTS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	input  logic        rank_valid,
	output logic        rank_stall,
	input  logic [28:0] rank,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [3:0]  position,
	output logic [3:0]  element,
	output logic        last
);

	localparam logic [rtp_pkg::DIGIT_W-1:0] MAX_N = rtp_pkg::DIGIT_W'(MAX_ELEMENTS);
	localparam int CNT_W = $clog2(rtp_pkg::RANK_W);

	rtp_pkg::state_t   state_q, state_d;
	rtp_pkg::div_cmd_t div_cmd;
	rtp_pkg::slot_cmd_t slot_cmd;

	logic [rtp_pkg::DIGIT_W-1:0] element_count_q;
	logic [rtp_pkg::DIGIT_W-1:0] eff_n;
	logic [rtp_pkg::DIGIT_W-1:0] n_q;
	logic [rtp_pkg::DIGIT_W-1:0] i_q;
	logic [rtp_pkg::DIGIT_W-1:0] pos_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [1:0]                  k_q;
	logic [rtp_pkg::DIGIT_W-1:0] digit;
	logic [rtp_pkg::RANK_W-1:0]  modulus;
	logic [rtp_pkg::RANK_W-1:0]  weight;
	logic                        mod_done;
	logic                        emit_done;

	always_comb begin
		if (element_count_q == '0) begin
			eff_n = rtp_pkg::DIGIT_W'(1);
		end else if (element_count_q > MAX_N) begin
			eff_n = MAX_N;
		end else begin
			eff_n = element_count_q;
		end
	end

	assign modulus   = rtp_pkg::FACT[n_q];
	assign weight    = rtp_pkg::FACT[i_q - rtp_pkg::DIGIT_W'(1)];
	assign mod_done  = (cnt_q == CNT_W'(rtp_pkg::RANK_W - 1));
	assign emit_done = (pos_q == n_q - rtp_pkg::DIGIT_W'(1));

	rtp_div_unit u_div (
		.clk     (clk),
		.cmd     (div_cmd),
		.rank    (rank),
		.modulus (modulus),
		.weight  (weight),
		.digit   (digit)
	);

	rtp_slot_alloc #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_slot (
		.clk      (clk),
		.cmd      (slot_cmd),
		.digit    (digit),
		.value    (i_q),
		.position (pos_q),
		.element  (element)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= rtp_pkg::ST_IDLE;
			element_count_q <= rtp_pkg::ELEMENT_COUNT_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				element_count_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rtp_pkg::ST_IDLE: begin
				n_q   <= eff_n;
				cnt_q <= '0;
			end
			rtp_pkg::ST_MOD: begin
				cnt_q <= cnt_q + CNT_W'(1);
				i_q   <= n_q;
				k_q   <= 2'd3;
			end
			rtp_pkg::ST_DIV: begin
				k_q <= k_q - 2'd1;
			end
			rtp_pkg::ST_PLACE: begin
				i_q   <= i_q - rtp_pkg::DIGIT_W'(1);
				k_q   <= 2'd3;
				pos_q <= '0;
			end
			rtp_pkg::ST_EMIT: begin
				if (!result_stall) begin
					pos_q <= pos_q + rtp_pkg::DIGIT_W'(1);
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	always_comb begin
		state_d      = state_q;
		div_cmd      = '0;
		slot_cmd     = '0;
		rank_stall   = 1'b1;
		result_valid = 1'b0;
		div_cmd.shift = k_q;
		case (state_q)
			rtp_pkg::ST_IDLE: begin
				rank_stall = 1'b0;
				if (rank_valid) begin
					div_cmd.load  = 1'b1;
					slot_cmd.init = 1'b1;
					state_d       = rtp_pkg::ST_MOD;
				end
			end
			rtp_pkg::ST_MOD: begin
				div_cmd.mod_step = 1'b1;
				if (mod_done) begin
					state_d = rtp_pkg::ST_DIV;
				end
			end
			rtp_pkg::ST_DIV: begin
				div_cmd.dig_step = 1'b1;
				if (k_q == 2'd0) begin
					state_d = rtp_pkg::ST_PLACE;
				end
			end
			rtp_pkg::ST_PLACE: begin
				slot_cmd.place = 1'b1;
				if (i_q == rtp_pkg::DIGIT_W'(1)) begin
					state_d = rtp_pkg::ST_EMIT;
				end else begin
					state_d = rtp_pkg::ST_DIV;
				end
			end
			rtp_pkg::ST_EMIT: begin
				result_valid = 1'b1;
				if (!result_stall && emit_done) begin
					state_d = rtp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rtp_pkg::ST_IDLE;
			end
		endcase
	end

	assign position = pos_q;
	assign last     = emit_done;

endmodule
